### src/swhd_pkg.sv
// ----------------------------------------------------------------------------
// swhd_pkg
// Shared constants, register codes and cell control types for the sliding
// window hit detector.
// ----------------------------------------------------------------------------
package swhd_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int TICK_W     = 32;
	localparam int CFG_W      = 7;
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int IDX_W      = $clog2(MAX_WINDOW);
	localparam int CMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	localparam logic [CFG_W-1:0] WIN_RST = CFG_W'(64);
	localparam logic [CFG_W-1:0] HIT_RST = CFG_W'(8);
	localparam logic [CFG_W-1:0] RUN_RST = CFG_W'(4);

	typedef enum logic [1:0] {
		REG_WINDOW  = 2'd0,
		REG_HIT_THR = 2'd1,
		REG_RUN_THR = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic              shift;
		logic [TICK_W-1:0] probe;
		logic [CNT_W-1:0]  win;
		logic [CNT_W-1:0]  count;
		logic [CFG_W-1:0]  run_thr;
	} cell_ctrl_t;

endpackage

### src/swhd_cell.sv
// ----------------------------------------------------------------------------
// swhd_cell
// One slot of the hit tick chain: holds a tick and its adjacency flag toward
// the next newer slot, shifts on a hit, flags expiry when it is the oldest.
// ----------------------------------------------------------------------------
module swhd_cell import swhd_pkg::*; (
	input  logic              clk,
	input  logic [IDX_W-1:0]  idx,
	input  cell_ctrl_t        ctrl,
	input  logic [TICK_W-1:0] tick_in,
	input  logic              adj_in,
	output logic [TICK_W-1:0] tick_q,
	output logic              adj_q,
	output logic              expired,
	output logic              run_ok
);

	logic [TICK_W-1:0] age;
	logic [CMP_W-1:0]  pos;

	assign pos = CMP_W'(idx);
	assign age = ctrl.probe - tick_q;

	// oldest slot is position count-1
	assign expired = (CMP_W'(ctrl.count) == pos + CMP_W'(1)) &&
		(age >= TICK_W'(ctrl.win));

	// flag this slot will hold after the shift, or slot outside the run
	assign run_ok = adj_in || (pos >= CMP_W'(ctrl.run_thr));

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			tick_q <= tick_in;
			adj_q  <= adj_in;
		end
	end

endmodule

### src/sliding_window_hit_detector.sv
// ----------------------------------------------------------------------------
// sliding_window_hit_detector
// Keeps the ticks of recent hits in a shifting chain of cells and raises an
// alarm on a hit when the count in the window or a run of adjacent ticks
// reaches its threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries hit and tick; output channel
//   (out_valid/out_stall) returns one alarm per input transaction.
//   Configuration writes (cfg_valid/cfg_ready, always ready) go to
//   window_length, hit_threshold, run_threshold by index 0..2; the user
//   must make them only while the block is idle, as the block does not
//   enforce this. Writing window_length empties the window.
//   An accepted transaction retires into the output register once the
//   output register is free, and its result then shows on out_valid. A new
//   transaction is taken only after the last has left the first stage: on
//   acceptance the oldest cell is checked for expiry against the new tick;
//   on retirement the chain shifts and both thresholds are evaluated. A
//   stalled result sits in the output register while one more transaction
//   is taken into the first stage; then in_stall holds until it drains.
//   Reset empties the window and loads window 64, count threshold 8, run threshold 4.
// ----------------------------------------------------------------------------
module sliding_window_hit_detector import swhd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              hit,
	input  logic [TICK_W-1:0] tick,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              alarm,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	logic [CFG_W-1:0]  win_len_q, hit_thr_q, run_thr_q;
	logic [CNT_W-1:0]  count_q;
	logic              valid_s1, hit_s1, expired_s1;
	logic [TICK_W-1:0] tick_s1;
	logic              out_valid_q, alarm_q;

	logic [CNT_W-1:0]  win, c1, c2;
	logic              accept, retire, expired_any, run_all, run_met, cnt_met;
	logic              adj_first;
	cell_ctrl_t        ctrl;

	logic [TICK_W-1:0]     cell_tick [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] cell_adj, cell_adj_in, cell_exp, cell_run;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = valid_s1;
	assign retire    = valid_s1 && (!out_valid_q || !out_stall);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign alarm     = alarm_q;

	always_comb begin
		if (win_len_q == '0)
			win = CNT_W'(1);
		else if (CMP_W'(win_len_q) > CMP_W'(MAX_WINDOW))
			win = CNT_W'(MAX_WINDOW);
		else
			win = CNT_W'(win_len_q);
	end

	assign ctrl.shift   = retire && hit_s1;
	assign ctrl.probe   = tick;
	assign ctrl.win     = win;
	assign ctrl.count   = count_q;
	assign ctrl.run_thr = run_thr_q;

	assign adj_first = (cell_tick[0] == tick_s1) ||
		((cell_tick[0] + TICK_W'(1)) == tick_s1);

	genvar k;
	generate
		for (k = 0; k < MAX_WINDOW; k++) begin : g_cell
			if (k == 0) begin : g_head
				assign cell_adj_in[k] = 1'b1;
				swhd_cell u_cell (
					.clk     (clk),
					.idx     (IDX_W'(k)),
					.ctrl    (ctrl),
					.tick_in (tick_s1),
					.adj_in  (cell_adj_in[k]),
					.tick_q  (cell_tick[k]),
					.adj_q   (cell_adj[k]),
					.expired (cell_exp[k]),
					.run_ok  (cell_run[k])
				);
			end else begin : g_body
				if (k == 1) begin : g_first
					assign cell_adj_in[k] = adj_first;
				end else begin : g_rest
					assign cell_adj_in[k] = cell_adj[k-1];
				end
				swhd_cell u_cell (
					.clk     (clk),
					.idx     (IDX_W'(k)),
					.ctrl    (ctrl),
					.tick_in (cell_tick[k-1]),
					.adj_in  (cell_adj_in[k]),
					.tick_q  (cell_tick[k]),
					.adj_q   (cell_adj[k]),
					.expired (cell_exp[k]),
					.run_ok  (cell_run[k])
				);
			end
		end
	endgenerate

	assign expired_any = |cell_exp;
	assign run_all     = &cell_run;

	assign c1 = count_q - CNT_W'(expired_s1);
	always_comb begin
		if (hit_s1 && (c1 < win))
			c2 = c1 + CNT_W'(1);
		else
			c2 = c1;
	end

	assign cnt_met = CMP_W'(c2) >= CMP_W'(hit_thr_q);
	assign run_met = (run_thr_q != '0) && (CMP_W'(run_thr_q) <= CMP_W'(c2)) && run_all;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			win_len_q   <= WIN_RST;
			hit_thr_q   <= HIT_RST;
			run_thr_q   <= RUN_RST;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (retire)
				valid_s1 <= 1'b0;

			if (retire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			if (retire)
				count_q <= c2;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_WINDOW: begin
						win_len_q <= cfg_data;
						count_q   <= '0;
					end
					REG_HIT_THR: hit_thr_q <= cfg_data;
					REG_RUN_THR: run_thr_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1     <= hit;
			tick_s1    <= tick;
			expired_s1 <= expired_any;
		end
		if (retire)
			alarm_q <= hit_s1 && (cnt_met || run_met);
	end

endmodule

### tb/sv/sliding_window_hit_detector_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_hit_detector_tb
// Self-checking bench for the sliding window hit detector. A scoreboard keeps
// its own ring of hit ticks. It predicts the alarm for every accepted input
// transaction and checks each output transaction in order. The run starts
// with directed ticks around the 32-bit wrap and the window and threshold
// corner settings. Random phases follow: mostly near-consecutive ticks under
// many register settings, with sender gaps, receiver stalls, and one long
// output hold that backs up the input.
// ----------------------------------------------------------------------------
module sliding_window_hit_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import swhd_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned PHASE_ITEMS  = 75;

	typedef enum int unsigned {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	class alarm_scoreboard;
		logic [TICK_W-1:0] ring [MAX_WINDOW];
		int unsigned       wr_ptr, rd_ptr, held;
		logic [CFG_W-1:0]  win_len, hit_thr, run_thr;
		bit                alarm_q [$];
		int unsigned       errors, checked, raised;

		function new();
			wr_ptr  = 0;
			rd_ptr  = 0;
			held    = 0;
			win_len = WIN_RST;
			hit_thr = HIT_RST;
			run_thr = RUN_RST;
			errors  = 0;
			checked = 0;
			raised  = 0;
		endfunction

		function int unsigned span();
			if (win_len == 0)
				return 1;
			if (win_len > MAX_WINDOW)
				return MAX_WINDOW;
			return 32'(win_len);
		endfunction

		function int unsigned step_fwd(int unsigned i, int unsigned w);
			return (i + 1 >= w) ? 0 : i + 1;
		endfunction

		function int unsigned step_back(int unsigned i, int unsigned w);
			return (i == 0 || i >= w) ? w - 1 : i - 1;
		endfunction

		function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_WINDOW: begin
					win_len = v;
					wr_ptr  = 0;
					rd_ptr  = 0;
					held    = 0;
				end
				REG_HIT_THR: hit_thr = v;
				REG_RUN_THR: run_thr = v;
				default: begin
				end
			endcase
		endfunction

		// walk back from the newest tick while each entry is equal or one less
		function bit run_reached(logic [TICK_W-1:0] now, int unsigned w);
			int unsigned       i, len, k;
			logic [TICK_W-1:0] prev, t, t_next;
			i    = step_back(wr_ptr, w);
			prev = now;
			len  = 0;
			for (k = 0; k < held; k++) begin
				t      = ring[i % MAX_WINDOW];
				t_next = t + 1'b1;
				if (t != prev && t_next != prev)
					return 0;
				len++;
				if (len == run_thr)
					return 1;
				prev = t;
				i    = step_back(i, w);
			end
			return 0;
		endfunction

		function void note_transaction(logic h, logic [TICK_W-1:0] now);
			int unsigned       w;
			logic [TICK_W-1:0] age;
			bit                a;
			w = span();
			a = 0;
			if (held > 0) begin
				age = now - ring[rd_ptr % MAX_WINDOW];
				if (age >= w) begin
					rd_ptr = step_fwd(rd_ptr, w);
					held--;
				end
			end
			if (h) begin
				ring[wr_ptr % MAX_WINDOW] = now;
				if (held >= w)
					rd_ptr = step_fwd(rd_ptr, w);
				else
					held++;
				wr_ptr = step_fwd(wr_ptr, w);
				a = run_reached(now, w) || (held >= hit_thr);
			end
			alarm_q.push_back(a);
		endfunction

		function void check_alarm(logic a);
			bit want;
			if (alarm_q.size() == 0) begin
				$display("%0t: alarm transaction with none expected, actual %b", $time, a);
				errors++;
				return;
			end
			want = alarm_q.pop_front();
			checked++;
			if (a !== want) begin
				$display("%0t: alarm mismatch, expected %b, actual %b", $time, want, a);
				errors++;
			end
			if (a === 1'b1)
				raised++;
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              hit       = 1'b0;
	logic [TICK_W-1:0] tick      = '0;
	logic              out_stall = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data  = '0;
	logic              in_stall, out_valid, alarm, cfg_ready;

	int unsigned       send_idle_pct = 0;
	int unsigned       recv_stall_pct = 0;
	int unsigned       hold_requests = 0;
	int unsigned       hold_served = 0;
	int unsigned       hold_left = 0;
	int unsigned       items_sent = 0;
	int unsigned       cycle_count = 0;
	logic [TICK_W-1:0] cur_tick = '0;
	alarm_scoreboard   sb = new();

	sliding_window_hit_detector u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.hit       (hit),
		.tick      (tick),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.alarm     (alarm),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2ns clk = ~clk;

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_served != hold_requests) begin
			hold_served = hold_served + 1;
			hold_left   = LONG_HOLD;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_alarm(alarm);
			if (in_valid && !in_stall)
				sb.note_transaction(hit, tick);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles", $time, cycle_count);
		$display("FAIL sliding_window_hit_detector");
		$finish;
	end

	function automatic void set_mode(idle_mode_t m);
		case (m)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct  = 78;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct  = 0;
				recv_stall_pct = 78;
			end
			default: begin
				send_idle_pct  = 23;
				recv_stall_pct = 23;
			end
		endcase
	endfunction

	// mostly consecutive or repeated ticks, some skips, steps back and jumps
	function automatic logic [TICK_W-1:0] next_tick(int unsigned w);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			cur_tick = cur_tick + 1'b1;
		else if (r >= 68 && r < 88)
			cur_tick = cur_tick + $urandom_range(w + 2, 2);
		else if (r >= 88 && r < 95)
			cur_tick = cur_tick - $urandom_range(3, 1);
		else if (r >= 95)
			cur_tick = $urandom();
		return cur_tick;
	endfunction

	task automatic send_item(input logic h, input logic [TICK_W-1:0] t);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		hit      <= h;
		tick     <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.checked < items_sent)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [CFG_W-1:0] w, h, r);
		logic [CFG_W-1:0] vals [3];
		vals = '{w, h, r};
		cfg_valid <= 1'b1;
		for (int unsigned i = 0; i < 3; i++) begin
			cfg_index <= reg_idx_t'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] w, h, r, input int unsigned n,
		input idle_mode_t m);
		int unsigned span_now;
		span_now = (w == 0) ? 1 : ((w > MAX_WINDOW) ? MAX_WINDOW : w);
		program_regs(w, h, r);
		set_mode(m);
		if ($urandom_range(1))
			cur_tick = $urandom();
		else
			cur_tick = '1 - $urandom_range(40);
		repeat (n)
			send_item($urandom_range(99) < 75, next_tick(span_now));
		settle();
	endtask

	initial begin
		int unsigned plan [11][3];
		plan = '{'{1, 1, 1}, '{2, 0, 2}, '{4, 3, 3}, '{8, 6, 4}, '{16, 9, 5},
			'{64, 20, 8}, '{64, 64, 64}, '{127, 127, 127}, '{5, 127, 0},
			'{100, 65, 65}, '{10, 4, 127}};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty ring, wrap of the tick, repeats, expiry
		set_mode(IDLE_NONE);
		send_item(1'b0, 32'h0000_0000);
		send_item(1'b1, 32'hFFFF_FFFD);
		send_item(1'b1, 32'hFFFF_FFFE);
		send_item(1'b1, 32'hFFFF_FFFF);
		send_item(1'b1, 32'h0000_0000);
		send_item(1'b1, 32'h0000_0000);
		send_item(1'b0, 32'h7FFF_FFFF);
		send_item(1'b1, 32'hFFFF_FFFF);
		send_item(1'b1, 32'h5555_5555);
		send_item(1'b1, 32'hAAAA_AAAA);
		settle();
		// window zero acts as one, count threshold zero, run check off
		program_regs(7'd0, 7'd0, 7'd0);
		send_item(1'b1, 32'd10);
		send_item(1'b1, 32'd10);
		send_item(1'b0, 32'd11);
		settle();
		// window above maximum, count threshold unreachable, run of one
		program_regs(7'd127, 7'd127, 7'd1);
		send_item(1'b1, 32'd5);
		send_item(1'b1, 32'd100);
		settle();
		// run longer than the ring holds
		program_regs(7'd3, 7'd127, 7'd5);
		send_item(1'b1, 32'd1);
		send_item(1'b1, 32'd2);
		send_item(1'b1, 32'd3);
		send_item(1'b1, 32'd4);
		send_item(1'b1, 32'd9);
		settle();

		for (int unsigned p = 0; p < 13; p++) begin
			if (p < 11)
				run_phase(CFG_W'(plan[p][0]), CFG_W'(plan[p][1]), CFG_W'(plan[p][2]),
					PHASE_ITEMS, idle_mode_t'(p % 4));
			else
				run_phase(CFG_W'($urandom_range(12, 1)), CFG_W'($urandom_range(12)),
					CFG_W'($urandom_range(12)), PHASE_ITEMS, idle_mode_t'(p % 4));
		end

		// long output hold while the sender keeps offering
		program_regs(7'd64, 7'd12, 7'd5);
		set_mode(IDLE_NONE);
		cur_tick = $urandom();
		hold_requests = hold_requests + 1;
		repeat (120)
			send_item($urandom_range(99) < 75, next_tick(MAX_WINDOW));
		settle();

		$display("Checked %0d alarm results for %0d input transactions, %0d alarms raised.",
			sb.checked, items_sent, sb.raised);
		$display("Covered tick wrap, window/threshold extremes, idle and stall mixes, long hold.");
		if (sb.errors == 0 && sb.alarm_q.size() == 0)
			$display("PASS sliding_window_hit_detector");
		else
			$display("FAIL sliding_window_hit_detector");
		$finish;
	end

endmodule

### files.f
src/swhd_pkg.sv
src/swhd_cell.sv
src/sliding_window_hit_detector.sv
tb/sv/sliding_window_hit_detector_tb.sv
